// ===== hdl/dhash_pkg.sv =====
// Shared widths, constants and types of the difference hash block.
`timescale 1ns / 1ps
package dhash_pkg;

    localparam int CFG_W     = 13;
    localparam int PIX_W     = 8;
    localparam int GRAY_W    = 18;
    localparam int HASH_W    = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int ROW_BITS  = 8;
    localparam int GRID_COLS = 9;
    localparam int GRID_ROWS = 8;
    localparam int IDX_W     = 4;

    localparam int MAX_DIMENSION_DEF = 4096;

    // Luma weights scaled by 1000.
    localparam logic [GRAY_W-1:0] GRAY_R = GRAY_W'(299);
    localparam logic [GRAY_W-1:0] GRAY_G = GRAY_W'(587);
    localparam logic [GRAY_W-1:0] GRAY_B = GRAY_W'(114);

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // Number of leading grid columns / rows already reached at the current pixel.
    typedef struct packed {
        logic [IDX_W-1:0] col_reach;
        logic [IDX_W-1:0] row_reach;
    } t_grid_reach;

endpackage

// ===== hdl/dhash_grid.sv =====
// Sample grid compare: how many grid columns and rows the current pixel has reached.
`timescale 1ns / 1ps
module dhash_grid #(
    parameter int CNT_W = 12,
    parameter int SZ_W  = 13
) (
    input  logic [SZ_W-1:0]          i_width,
    input  logic [SZ_W-1:0]          i_height,
    input  logic [CNT_W-1:0]         i_col,
    input  logic [CNT_W-1:0]         i_row,
    output dhash_pkg::t_grid_reach   o_reach
);
    import dhash_pkg::*;

    localparam int PW = SZ_W + 4;

    logic [GRID_COLS-1:0] col_hit;
    logic [GRID_ROWS-1:0] row_hit;
    logic [PW-1:0]        w_m1;
    logic [PW-1:0]        h_m1;
    logic [PW-1:0]        col_lim;
    logic [PW-1:0]        row_lim;

    // floor(k*(W-1)/8) <= x  is  k*(W-1) < 8*(x+1); rows likewise with 7.
    always_comb begin
        w_m1    = PW'(i_width) - PW'(1);
        h_m1    = PW'(i_height) - PW'(1);
        col_lim = (PW'(i_col) + PW'(1)) << 3;
        row_lim = (PW'(i_row) + PW'(1)) * PW'(GRID_ROWS - 1);
        for (int k = 0; k < GRID_COLS; k++) begin
            col_hit[k] = (PW'(k) * w_m1) < col_lim;
        end
        for (int j = 0; j < GRID_ROWS; j++) begin
            row_hit[j] = (PW'(j) * h_m1) < row_lim;
        end
        o_reach.col_reach = IDX_W'($countones(col_hit));
        o_reach.row_reach = IDX_W'($countones(row_hit));
    end

endmodule

// ===== hdl/difference_hash_64bit_unit.sv =====
// Top level of the 64-bit difference hash: pixel stream in, one hash per frame out.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  pixel    | in        | i_in_valid / o_in_ready   | i_red, i_green, i_blue
//  hash     | out       | o_out_valid / i_out_ready | o_hash, o_too_small
//  config   | in        | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// One pixel beat per cycle; the hash appears in the output register in the cycle
// after the frame's last pixel is accepted. Reset (synchronous, active low) clears the
// frame counters, the size registers and the output valid flag. A stalled hash
// beat holds the pixel channel only at the next frame's last pixel; all
// other pixels keep flowing.
`timescale 1ns / 1ps
module difference_hash_64bit_unit #(
    parameter int MAX_DIMENSION = dhash_pkg::MAX_DIMENSION_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [dhash_pkg::PIX_W-1:0]  i_red,
    input  logic [dhash_pkg::PIX_W-1:0]  i_green,
    input  logic [dhash_pkg::PIX_W-1:0]  i_blue,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [dhash_pkg::HASH_W-1:0] o_hash,
    output logic                         o_too_small,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dhash_pkg::ADDR_W-1:0] paddr,
    input  logic [dhash_pkg::DATA_W-1:0] pwdata,
    output logic [dhash_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);
    import dhash_pkg::*;

    localparam int EFF_MAX = (MAX_DIMENSION < 8191) ? MAX_DIMENSION : 8191;
    localparam int CNT_W   = $clog2(EFF_MAX);
    localparam int SZ_W    = $clog2(EFF_MAX + 1);
    localparam int LW      = SZ_W + 1;

    logic [CFG_W-1:0]    r_width;
    logic [CFG_W-1:0]    r_height;
    logic [CNT_W-1:0]    r_col;
    logic [CNT_W-1:0]    r_row;
    logic [IDX_W-1:0]    r_sci;
    logic [IDX_W-1:0]    r_sri;
    logic [GRAY_W-1:0]   r_last;
    logic [ROW_BITS-1:0] r_row_bits;
    logic [HASH_W-1:0]   r_acc;
    logic                r_out_valid;
    logic [HASH_W-1:0]   r_hash;
    logic                r_too_small;

    logic [CNT_W-1:0]    n_col;
    logic [CNT_W-1:0]    n_row;
    logic [IDX_W-1:0]    n_sci;
    logic [IDX_W-1:0]    n_sri;
    logic [GRAY_W-1:0]   n_last;
    logic [ROW_BITS-1:0] n_row_bits;
    logic [HASH_W-1:0]   n_acc;

    logic [SZ_W-1:0]     eff_w;
    logic [SZ_W-1:0]     eff_h;
    logic                small_frame;
    logic [GRAY_W-1:0]   gray;
    t_grid_reach         reach;
    logic                in_grid;
    logic                take;
    logic [ROW_BITS-1:0] row_bits_upd;
    logic                row_end;
    logic                frame_end;
    logic                accept;
    logic                cfg_wr;

    function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] v);
        logic [SZ_W-1:0] s;
        if (v == '0) begin
            s = SZ_W'(1);
        end else if (v > CFG_W'(EFF_MAX)) begin
            s = SZ_W'(EFF_MAX);
        end else begin
            s = SZ_W'(v);
        end
        return s;
    endfunction

    dhash_grid #(
        .CNT_W (CNT_W),
        .SZ_W  (SZ_W)
    ) u_grid (
        .i_width  (eff_w),
        .i_height (eff_h),
        .i_col    (r_col),
        .i_row    (r_row),
        .o_reach  (reach)
    );

    assign eff_w       = eff_size(r_width);
    assign eff_h       = eff_size(r_height);
    assign small_frame = (eff_w < SZ_W'(2)) || (eff_h < SZ_W'(2));
    assign gray        = GRAY_W'(i_red) * GRAY_R + GRAY_W'(i_green) * GRAY_G
                       + GRAY_W'(i_blue) * GRAY_B;

    assign row_end   = (LW'(r_col) + LW'(1)) >= LW'(eff_w);
    assign frame_end = row_end && ((LW'(r_row) + LW'(1)) >= LW'(eff_h));

    // Hold the pixel channel only when the hash beat it would produce has nowhere to go.
    assign o_in_ready = !r_out_valid || i_out_ready || !frame_end;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        in_grid      = !small_frame && (r_sri < reach.row_reach);
        take         = in_grid && (r_sci < reach.col_reach);
        row_bits_upd = r_row_bits;
        // Only the first of several coincident columns can differ from the last sample.
        if (take && (r_sci != '0) && (r_last < gray)) begin
            row_bits_upd[3'(r_sci - IDX_W'(1))] = 1'b1;
        end

        n_col      = r_col;
        n_row      = r_row;
        n_sci      = take ? reach.col_reach : r_sci;
        n_sri      = r_sri;
        n_last     = take ? gray : r_last;
        n_row_bits = row_bits_upd;
        n_acc      = r_acc;

        if (!row_end) begin
            n_col = r_col + CNT_W'(1);
        end else begin
            if (in_grid) begin
                // Copy the row's bits into every grid row that maps to this pixel row.
                for (int j = 0; j < GRID_ROWS; j++) begin
                    if ((IDX_W'(j) >= r_sri) && (IDX_W'(j) < reach.row_reach)) begin
                        n_acc[j*ROW_BITS +: ROW_BITS] =
                            r_acc[j*ROW_BITS +: ROW_BITS] | row_bits_upd;
                    end
                end
                n_sri = reach.row_reach;
            end
            n_row_bits = '0;
            n_sci      = '0;
            n_last     = '0;
            n_col      = '0;
            if (!frame_end) begin
                n_row = r_row + CNT_W'(1);
            end else begin
                n_row = '0;
                n_sri = '0;
            end
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        unique case (t_cfg_idx'(paddr[2]))
            CFG_WIDTH:  prdata = DATA_W'(r_width);
            CFG_HEIGHT: prdata = DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(paddr[2]))
                CFG_WIDTH:  r_width  <= pwdata[CFG_W-1:0];
                CFG_HEIGHT: r_height <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_sci      <= '0;
            r_sri      <= '0;
            r_last     <= '0;
            r_row_bits <= '0;
            r_acc      <= '0;
        end else if (accept) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_sci      <= n_sci;
            r_sri      <= n_sri;
            r_last     <= n_last;
            r_row_bits <= n_row_bits;
            r_acc      <= frame_end ? '0 : n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && frame_end) begin
            r_hash      <= small_frame ? '0 : n_acc;
            r_too_small <= small_frame;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_hash      = r_hash;
    assign o_too_small = r_too_small;

endmodule
